@@ src/assert_macros.svh @@
// Assertion macros for the RTL files; rra_back.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds in every cycle out of reset.
`define RRA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define RRA_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RRA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rra_pkg.sv @@
// Types and constants of the range reservation admission block.
package rra_pkg;

  localparam int unsigned IDX_W  = 12;
  localparam int unsigned DAY_W  = 13;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OUT_W  = 20;

  localparam logic [DAY_W-1:0] DAYS_RESET = 13'd4096;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_REQ  = 1'b1
  } rra_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TAKE,
    ST_FINISH
  } rra_state_e;

  typedef struct packed {
    rra_kind_e         kind;
    logic [IDX_W-1:0]  slot;
    logic [DATA_W-1:0] capacity;
    logic [DATA_W-1:0] amount;
    logic [IDX_W-1:0]  first_day;
    logic [IDX_W-1:0]  last_day;
  } rra_in_t;

  typedef struct packed {
    logic             overbooked;
    logic [OUT_W-1:0] first_failed_request;
    logic [OUT_W-1:0] requests_seen;
  } rra_out_t;

  // Classified command: lo is the load slot or the range start, hi the load slot or the clipped range end.
  typedef struct packed {
    rra_kind_e         kind;
    logic              skip;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [DATA_W-1:0] data;
  } rra_cmd_t;

endpackage

@@ src/range_reservation_admission.sv @@
// Top level: request/load item admission against a per-slot capacity table.
// A load item writes the table from IDLE and then registers its result in FINISH.
// A request over n clipped slots runs a check pass, then a take pass (skipped on failure),
// each one table read per cycle, before FINISH; an empty or frozen request goes straight to FINISH.
// The back part takes a new item only in IDLE, once FINISH has handed off the last result.
// Reset clears status, counters and queue; days_in_use resets to 4096, table undefined.
module range_reservation_admission #(
  parameter int unsigned SLOTS      = 4096,
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [rra_pkg::DAY_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  rra_pkg::rra_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rra_pkg::rra_out_t         out_data_o
);
  import rra_pkg::*;

  logic     f_valid, f_ready, b_valid, b_ready;
  rra_cmd_t f_cmd, b_cmd;

  rra_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  rra_fifo u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_cmd)
  );

  rra_back #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ src/rra_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rra_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rra_fifo.sv @@
// Two-entry command queue between the front and back parts.
module rra_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  rra_pkg::rra_cmd_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output rra_pkg::rra_cmd_t pop_data_o
);
  import rra_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  rra_cmd_t        mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

@@ src/rra_front.sv @@
// Front part: holds days_in_use, clips request ranges and classifies items.
module rra_front #(
  parameter int unsigned SLOTS = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rra_pkg::DAY_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rra_pkg::rra_in_t            in_data_i,
  output logic                        cmd_valid_o,
  input  logic                        cmd_ready_i,
  output rra_pkg::rra_cmd_t           cmd_o
);
  import rra_pkg::*;

  localparam logic [20:0] SLOTS_W = 21'(SLOTS);

  logic [DAY_W-1:0] days_q;
  logic [DAY_W-1:0] used, lim;
  logic [IDX_W-1:0] hi_c;
  logic             empty, load_ok;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      days_q <= DAYS_RESET;
    end else if (cfg_valid_i) begin
      days_q <= cfg_data_i;
    end
  end

  always_comb begin
    used    = (21'(days_q) > SLOTS_W) ? DAY_W'(SLOTS_W) : days_q;
    lim     = used - DAY_W'(1);
    hi_c    = (DAY_W'(in_data_i.last_day) > lim) ? IDX_W'(lim) : in_data_i.last_day;
    empty   = (used == '0) || (in_data_i.first_day > hi_c);
    load_ok = (21'(in_data_i.slot) < SLOTS_W);

    cmd_o.kind = in_data_i.kind;
    if (in_data_i.kind == KIND_REQ) begin
      cmd_o.skip = empty;
      cmd_o.lo   = in_data_i.first_day;
      cmd_o.hi   = hi_c;
      cmd_o.data = in_data_i.amount;
    end else begin
      cmd_o.skip = !load_ok;
      cmd_o.lo   = in_data_i.slot;
      cmd_o.hi   = in_data_i.slot;
      cmd_o.data = in_data_i.capacity;
    end
  end

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

endmodule

@@ src/rra_back.sv @@
// Back part: capacity table sequencer, status registers and result register.
`include "assert_macros.svh"

module rra_back #(
  parameter int unsigned SLOTS      = 4096,
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  rra_pkg::rra_cmd_t cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rra_pkg::rra_out_t out_data_o
);
  import rra_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);

  rra_state_e            state_q, state_d;
  logic [DAY_W-1:0]      ptr_q, ptr_d;
  logic [AW-1:0]         wa_q, wa_d;
  logic                  rv_q, rv_d;
  logic                  bad_q, bad_d;
  logic [IDX_W-1:0]      lo_q, lo_d, hi_q, hi_d;
  logic [DATA_W-1:0]     amt_q, amt_d;
  logic                  failed_q, failed_d;
  logic [COUNT_BITS-1:0] ord_q, ord_d, cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  rra_out_t              out_q, out_d;

  logic                  issue;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_W-1:0]     ram_wdata, ram_rdata;

  rra_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rv_q        <= 1'b0;
      bad_q       <= 1'b0;
      failed_q    <= 1'b0;
      ord_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rv_q        <= rv_d;
      bad_q       <= bad_d;
      failed_q    <= failed_d;
      ord_q       <= ord_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    wa_q  <= wa_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    amt_q <= amt_d;
    out_q <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    wa_d        = wa_q;
    rv_d        = 1'b0;
    bad_d       = bad_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    amt_d       = amt_q;
    failed_d    = failed_q;
    ord_d       = ord_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    cmd_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    issue       = (ptr_q <= DAY_W'(hi_q));

    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          lo_d  = cmd_i.lo;
          hi_d  = cmd_i.hi;
          amt_d = cmd_i.data;
          ptr_d = DAY_W'(cmd_i.lo);
          bad_d = 1'b0;
          if (cmd_i.kind == KIND_REQ) begin
            if (cnt_q != '1) begin
              cnt_d = cnt_q + COUNT_BITS'(1);
            end
            state_d = (!failed_q && !cmd_i.skip) ? ST_CHECK : ST_FINISH;
          end else begin
            ram_we    = !failed_q && !cmd_i.skip;
            ram_waddr = AW'(cmd_i.lo);
            ram_wdata = cmd_i.data;
            state_d   = ST_FINISH;
          end
        end
      end
      ST_CHECK: begin
        if (issue) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ptr_q);
          ptr_d     = ptr_q + DAY_W'(1);
          rv_d      = 1'b1;
        end
        if (rv_q && (ram_rdata < amt_q)) begin
          bad_d = 1'b1;
        end
        if (!issue && !rv_q) begin
          if (bad_q) begin
            failed_d = 1'b1;
            ord_d    = cnt_q;
            state_d  = ST_FINISH;
          end else begin
            ptr_d   = DAY_W'(lo_q);
            state_d = ST_TAKE;
          end
        end
      end
      ST_TAKE: begin
        if (issue) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ptr_q);
          wa_d      = AW'(ptr_q);
          ptr_d     = ptr_q + DAY_W'(1);
          rv_d      = 1'b1;
        end
        if (rv_q) begin
          ram_we    = 1'b1;
          ram_waddr = wa_q;
          ram_wdata = ram_rdata - amt_q;
        end
        if (!issue && !rv_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                = 1'b1;
          out_d.overbooked           = failed_q;
          out_d.first_failed_request = OUT_W'(ord_q);
          out_d.requests_seen        = OUT_W'(cnt_q);
          state_d                    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RRA_ASSERT_NEXT(a_failed_sticky, clk_i, rst_ni, failed_q, failed_q,
    "failure flag cleared")
  `RRA_ASSERT_IMPL(a_ord_nonzero, clk_i, rst_ni, failed_q, ord_q != '0,
    "failure latched without ordinal")
  `RRA_ASSERT_IMPL(a_write_state, clk_i, rst_ni, ram_we,
    (state_q == ST_IDLE) || (state_q == ST_TAKE), "table written outside load or take")
  `RRA_ASSERT_IMPL(a_ptr_bound, clk_i, rst_ni,
    (state_q == ST_CHECK) || (state_q == ST_TAKE), ptr_q <= DAY_W'(hi_q) + DAY_W'(1),
    "range pointer ran past end")

endmodule

@@ tb/sv/range_reservation_admission_tb.sv @@
// Self-checking testbench for range_reservation_admission: predicted status vs. DUT results.
module range_reservation_admission_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rra_pkg::*;

  localparam int SLOT_COUNT  = 4096;
  localparam int COUNT_MAX   = (1 << 20) - 1;
  localparam int CYCLE_LIMIT = 5000000;

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  logic [DAY_W-1:0] cfg_data_i = '0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  rra_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  rra_out_t out_data_o;

  range_reservation_admission dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Predicted table and status.
  logic [DATA_W-1:0] cap_left [SLOT_COUNT];
  bit                slot_loaded [SLOT_COUNT];
  logic [OUT_W-1:0]  requests_count;
  logic [OUT_W-1:0]  failed_at;
  bit                overbooked_flag;
  logic [DAY_W-1:0]  days_cfg;

  rra_out_t expected_status_q [$];
  rra_out_t want_status;
  rra_out_t got_status;
  int       mismatch_count = 0;
  int       result_count   = 0;
  int       cycle_count    = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;

  function automatic int eff_last(input int hi);
    int used;
    used = days_cfg;
    if (used > SLOT_COUNT) used = SLOT_COUNT;
    if (used == 0) return -1;
    return (hi > used - 1) ? used - 1 : hi;
  endfunction

  function automatic bit reads_table(input int lo, input int hi);
    return !overbooked_flag && lo <= eff_last(hi);
  endfunction

  function automatic int first_gap(input int lo, input int hi);
    if (!reads_table(lo, hi)) return -1;
    for (int i = lo; i <= eff_last(hi); i++) begin
      if (!slot_loaded[i]) return i;
    end
    return -1;
  endfunction

  function automatic logic [DATA_W-1:0] least_left(input int lo, input int hi);
    logic [DATA_W-1:0] m;
    m = '1;
    for (int i = lo; i <= eff_last(hi); i++) begin
      if (cap_left[i] < m) m = cap_left[i];
    end
    return m;
  endfunction

  function automatic rra_out_t admit_item(input rra_in_t it);
    rra_out_t st;
    int       lo;
    int       e;
    bit       fits;
    if (it.kind == KIND_LOAD) begin
      if (!overbooked_flag) begin
        cap_left[it.slot]    = it.capacity;
        slot_loaded[it.slot] = 1'b1;
      end
    end else begin
      if (requests_count < COUNT_MAX) requests_count++;
      lo = it.first_day;
      e  = eff_last(it.last_day);
      if (!overbooked_flag && lo <= e) begin
        fits = 1'b1;
        for (int i = lo; i <= e; i++) begin
          if (cap_left[i] < it.amount) fits = 1'b0;
        end
        if (fits) begin
          for (int i = lo; i <= e; i++) cap_left[i] = cap_left[i] - it.amount;
        end else begin
          overbooked_flag = 1'b1;
          failed_at       = requests_count;
        end
      end
    end
    st.overbooked           = overbooked_flag;
    st.first_failed_request = failed_at;
    st.requests_seen        = requests_count;
    return st;
  endfunction

  function automatic rra_in_t load_item(input int slot, input logic [DATA_W-1:0] cap);
    rra_in_t it;
    it.kind      = KIND_LOAD;
    it.slot      = IDX_W'(slot);
    it.capacity  = cap;
    it.amount    = $urandom;
    it.first_day = IDX_W'($urandom);
    it.last_day  = IDX_W'($urandom);
    return it;
  endfunction

  function automatic rra_in_t req_item(input int lo, input int hi, input logic [DATA_W-1:0] amt);
    rra_in_t it;
    it.kind      = KIND_REQ;
    it.slot      = IDX_W'($urandom);
    it.capacity  = $urandom;
    it.amount    = amt;
    it.first_day = IDX_W'(lo);
    it.last_day  = IDX_W'(hi);
    return it;
  endfunction

  // Amount that never overbooks while the table is live.
  function automatic logic [DATA_W-1:0] fitting_amount(input int lo, input int hi);
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] amt;
    int                roll;
    amt = $urandom;
    if (reads_table(lo, hi)) begin
      m    = least_left(lo, hi);
      roll = $urandom_range(0, 99);
      if (roll < 20) amt = '0;
      else if (roll < 40) amt = m;
      else if (amt > m) amt = $urandom_range(m);
    end
    return amt;
  endfunction

  function automatic rra_in_t random_load();
    int                slot;
    int                roll;
    logic [DATA_W-1:0] cap;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 1)) begin
      slot = $urandom_range(0, SLOT_COUNT - 1);
    end else begin
      slot = $urandom_range(0, 31);
      if ($urandom_range(0, 1)) slot += SLOT_COUNT - 32;
    end
    if (roll < 10) cap = '1;
    else if (roll < 20) cap = $urandom_range(255);
    else cap = $urandom;
    return load_item(slot, cap);
  endfunction

  // A range that would read an unloaded slot is cut short before it, or moved to one slot near either table end.
  function automatic rra_in_t random_request(input int wide_pct);
    int lo;
    int hi;
    int tmp;
    int gap;
    if ($urandom_range(0, 99) < wide_pct) begin
      lo = $urandom_range(0, SLOT_COUNT - 1);
      hi = $urandom_range(0, SLOT_COUNT - 1);
    end else begin
      lo = $urandom_range(0, 31);
      if ($urandom_range(0, 1)) lo += SLOT_COUNT - 32;
      hi = lo + $urandom_range(0, 15);
      if (hi > SLOT_COUNT - 1) hi = SLOT_COUNT - 1;
      if ($urandom_range(0, 9) == 0) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
    end
    gap = first_gap(lo, hi);
    if (gap == lo) begin
      lo = $urandom_range(0, 7);
      if ($urandom_range(0, 1)) lo += SLOT_COUNT - 8;
      hi = lo;
    end else if (gap > lo) begin
      hi = gap - 1;
    end
    return req_item(lo, hi, fitting_amount(lo, hi));
  endfunction

  task automatic push_item(input rra_in_t it);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    expected_status_q.push_back(admit_item(it));
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_days(input logic [DAY_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    days_cfg = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed_extremes();
    push_item(load_item(0, '0));
    push_item(load_item(SLOT_COUNT - 1, '1));
    for (int i = 1; i < 8; i++) push_item(load_item(i, $urandom | 32'h8000_0000));
    for (int i = SLOT_COUNT - 8; i < SLOT_COUNT - 1; i++) begin
      push_item(load_item(i, $urandom | 32'h8000_0000));
    end
    push_item(req_item(0, 0, '0));                          // zero amount on empty slot
    push_item(req_item(SLOT_COUNT - 1, SLOT_COUNT - 1, '1)); // takes all
    push_item(req_item(SLOT_COUNT - 1, 0, '1));              // empty range
    push_item(load_item(0, '1));
    push_item(load_item(SLOT_COUNT - 1, '1));
    push_item(req_item(0, 7, least_left(0, 7)));
    push_item(req_item(SLOT_COUNT - 8, SLOT_COUNT - 1,
                       fitting_amount(SLOT_COUNT - 8, SLOT_COUNT - 1)));
  endtask

  task automatic test_day_clipping();
    settle();
    write_days(DAY_W'(1));
    push_item(req_item(0, SLOT_COUNT - 1, fitting_amount(0, SLOT_COUNT - 1)));
    push_item(req_item(SLOT_COUNT - 8, SLOT_COUNT - 1, '1));
    settle();
    write_days('0);
    push_item(req_item(0, 0, '1));
    push_item(req_item(0, SLOT_COUNT - 1, '1));
    settle();
    write_days('1);                                          // above table size
    push_item(req_item(SLOT_COUNT - 8, SLOT_COUNT - 1,
                       fitting_amount(SLOT_COUNT - 8, SLOT_COUNT - 1)));
    settle();
    write_days(DAYS_RESET);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
    settle();
    case ($urandom_range(0, 3))
      0: write_days(DAYS_RESET);
      1: write_days(DAY_W'($urandom_range(1, SLOT_COUNT)));
      2: write_days(DAY_W'($urandom_range(SLOT_COUNT - 7, SLOT_COUNT - 1)));
      default: write_days(DAY_W'($urandom_range(1, 40)));
    endcase
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 40) push_item(random_load());
      else push_item(random_request(15));
    end
  endtask

  task automatic test_overbooking();
    settle();
    write_days(DAYS_RESET);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_item(load_item(3, 32'd100));
    push_item(req_item(0, 7, least_left(0, 7) + 1));
    push_item(req_item(0, 7, '1));
    push_item(load_item(3, '0));                            // frozen: ignored
    push_item(req_item(3, 3, 32'd1));
  endtask

  task automatic test_frozen_table();
    settle();
    write_days(DAY_W'($urandom_range(1, SLOT_COUNT)));
    send_idle_pct  = 19;
    recv_stall_pct = 19;
    for (int i = 0; i < 20; i++) begin
      if ($urandom_range(0, 99) < 30) push_item(random_load());
      else push_item(random_request(70));
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_status = out_data_o;
      result_count++;
      if (expected_status_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result %0d unexpected: ob=%0d ffr=%0d seen=%0d", result_count,
                   got_status.overbooked, got_status.first_failed_request,
                   got_status.requests_seen);
        end
      end else begin
        want_status = expected_status_q.pop_front();
        if (got_status.overbooked !== want_status.overbooked ||
            got_status.first_failed_request !== want_status.first_failed_request ||
            got_status.requests_seen !== want_status.requests_seen) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result %0d: expected ob=%0d ffr=%0d seen=%0d, got ob=%0d ffr=%0d seen=%0d",
                     result_count, want_status.overbooked, want_status.first_failed_request,
                     want_status.requests_seen, got_status.overbooked,
                     got_status.first_failed_request, got_status.requests_seen);
          end
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      cap_left[i]    = '0;
      slot_loaded[i] = 1'b0;
    end
    requests_count  = '0;
    failed_at       = '0;
    overbooked_flag = 1'b0;
    days_cfg        = DAYS_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_day_clipping();
    test_random_traffic(0, 0, 12);
    test_random_traffic(53, 0, 12);
    test_random_traffic(0, 53, 12);
    test_random_traffic(19, 19, 12);
    test_overbooking();
    test_frozen_table();

    settle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_status_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/rra_pkg.sv
src/rra_ram.sv
src/rra_fifo.sv
src/rra_front.sv
src/rra_back.sv
src/range_reservation_admission.sv
tb/sv/range_reservation_admission_tb.sv
